// File: sv/q2rm_pkg.sv
// ----------------------------------------------------------------------------
// q2rm_pkg
// Types and constants for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package q2rm_pkg;

	localparam int COMP_W   = 16;           // Q2.14 component / entry width
	localparam int FRAC_W   = 14;
	localparam int PROD_W   = 2 * COMP_W;   // one product, Q4.28
	localparam int SUM_W    = PROD_W + 1;   // S = sum of four squares
	localparam int NUM_W    = PROD_W + 2;   // signed numerator
	localparam int MAG_W    = NUM_W - 1;
	localparam int DEN_W    = SUM_W + 1;    // 2S
	localparam int QUO_W    = FRAC_W + 1;   // quotient bits, result below 2^15
	localparam int REM_W    = MAG_W + QUO_W + 1;
	localparam int N_ENT    = 9;

	typedef struct packed {
		logic signed [COMP_W-1:0] q_w;
		logic signed [COMP_W-1:0] q_x;
		logic signed [COMP_W-1:0] q_y;
		logic signed [COMP_W-1:0] q_z;
	} quat_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] m00;
		logic signed [COMP_W-1:0] m01;
		logic signed [COMP_W-1:0] m02;
		logic signed [COMP_W-1:0] m10;
		logic signed [COMP_W-1:0] m11;
		logic signed [COMP_W-1:0] m12;
		logic signed [COMP_W-1:0] m20;
		logic signed [COMP_W-1:0] m21;
		logic signed [COMP_W-1:0] m22;
		logic                     degenerate;
	} mat_t;

endpackage

// File: sv/q2rm_stream_if.sv
// ----------------------------------------------------------------------------
// q2rm_stream_if
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface q2rm_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a Q2.14 quaternion, any length, into a normalised 3x3 rotation
// matrix in Q2.14.
//
// Channels: quat (sink) takes one quaternion per request; mat (source) gives
// the nine entries and the degenerate flag. Both valid/ready.
// Pipeline from acceptance to mat.valid: products, sums, divider
// set-up, one stage per quotient bit (15) and the output register.
// Throughput: one quaternion per cycle while mat is not stalled; the
// fifteen restoring divider stages per entry set the depth, not the rate.
// Stall: while mat.valid is high and mat.ready low the whole pipeline holds;
// quat.ready is low in that time. Nothing is dropped or repeated.
// Reset: arst_n clears all valid bits; the pipeline comes up empty.
// A zero quaternion gives zero entries with degenerate set.
// Rounding is to nearest, ties away from zero.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix
	import q2rm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	q2rm_stream_if.sink          quat,
	q2rm_stream_if.source        mat
);

	localparam int DIV_ST = QUO_W;

	logic adv;
	assign adv        = !mat.valid || mat.ready;
	assign quat.ready = adv;

	// stage 1: products
	logic                     v_s1;
	logic signed [PROD_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PROD_W-1:0] xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= quat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s1 <= quat.data.q_w * quat.data.q_w;
			xx_s1 <= quat.data.q_x * quat.data.q_x;
			yy_s1 <= quat.data.q_y * quat.data.q_y;
			zz_s1 <= quat.data.q_z * quat.data.q_z;
			xy_s1 <= quat.data.q_x * quat.data.q_y;
			wz_s1 <= quat.data.q_w * quat.data.q_z;
			xz_s1 <= quat.data.q_x * quat.data.q_z;
			wy_s1 <= quat.data.q_w * quat.data.q_y;
			yz_s1 <= quat.data.q_y * quat.data.q_z;
			wx_s1 <= quat.data.q_w * quat.data.q_x;
		end
	end

	// stage 2: squared norm and numerators
	logic                    v_s2;
	logic [SUM_W-1:0]        s_s2;
	logic signed [NUM_W-1:0] num_s2 [N_ENT];
	logic signed [NUM_W-1:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;

	assign e_ww = NUM_W'(ww_s1);
	assign e_xx = NUM_W'(xx_s1);
	assign e_yy = NUM_W'(yy_s1);
	assign e_zz = NUM_W'(zz_s1);
	assign e_xy = NUM_W'(xy_s1);
	assign e_wz = NUM_W'(wz_s1);
	assign e_xz = NUM_W'(xz_s1);
	assign e_wy = NUM_W'(wy_s1);
	assign e_yz = NUM_W'(yz_s1);
	assign e_wx = NUM_W'(wx_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s2      <= SUM_W'(e_ww + e_xx + e_yy + e_zz);
			num_s2[0] <= e_ww + e_xx - e_yy - e_zz;
			num_s2[1] <= (e_xy - e_wz) <<< 1;
			num_s2[2] <= (e_xz + e_wy) <<< 1;
			num_s2[3] <= (e_xy + e_wz) <<< 1;
			num_s2[4] <= e_ww - e_xx + e_yy - e_zz;
			num_s2[5] <= (e_yz - e_wx) <<< 1;
			num_s2[6] <= (e_xz - e_wy) <<< 1;
			num_s2[7] <= (e_yz + e_wx) <<< 1;
			num_s2[8] <= e_ww - e_xx - e_yy + e_zz;
		end
	end

	// stage 3 feeds divider step 0; index k holds the state after k quotient bits
	logic               v_d   [DIV_ST+1];
	logic               deg_d [DIV_ST+1];
	logic [DEN_W-1:0]   den_d [DIV_ST+1];
	logic [N_ENT-1:0]   neg_d [DIV_ST+1];
	logic [REM_W-1:0]   rem_d [DIV_ST+1][N_ENT];
	logic [QUO_W-1:0]   quo_d [DIV_ST+1][N_ENT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (adv) begin
			v_d[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_d[0] <= (s_s2 == '0);
			den_d[0] <= {s_s2, 1'b0};
			for (int i = 0; i < N_ENT; i++) begin
				neg_d[0][i] <= num_s2[i][NUM_W-1];
				// rounding: (|num| * 2^15 + S) / 2S
				rem_d[0][i] <= {1'b0, (num_s2[i][NUM_W-1] ? MAG_W'(-num_s2[i])
					: MAG_W'(num_s2[i])), {QUO_W{1'b0}}} + REM_W'(s_s2);
				quo_d[0][i] <= '0;
			end
		end
	end

	for (genvar k = 0; k < DIV_ST; k++) begin : g_div
		localparam int B = DIV_ST - 1 - k;
		logic [REM_W-1:0] trial;
		assign trial = REM_W'(den_d[k]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else if (adv) begin
				v_d[k+1] <= v_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				deg_d[k+1] <= deg_d[k];
				den_d[k+1] <= den_d[k];
				neg_d[k+1] <= neg_d[k];
				for (int i = 0; i < N_ENT; i++) begin
					if (rem_d[k][i] >= trial) begin
						rem_d[k+1][i]    <= rem_d[k][i] - trial;
						quo_d[k+1][i]    <= quo_d[k][i] | (QUO_W'(1) << B);
					end else begin
						rem_d[k+1][i]    <= rem_d[k][i];
						quo_d[k+1][i]    <= quo_d[k][i];
					end
				end
			end
		end
	end

	// output register; quotient stays below 2^15 so no clamp is reached
	logic               v_q;
	logic [COMP_W-1:0]  ent [N_ENT];
	mat_t               res_q;

	always_comb begin
		for (int i = 0; i < N_ENT; i++) begin
			if (deg_d[DIV_ST]) begin
				ent[i] = '0;
			end else if (neg_d[DIV_ST][i]) begin
				ent[i] = -COMP_W'(quo_d[DIV_ST][i]);
			end else begin
				ent[i] = COMP_W'(quo_d[DIV_ST][i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= v_d[DIV_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.m00        <= ent[0];
			res_q.m01        <= ent[1];
			res_q.m02        <= ent[2];
			res_q.m10        <= ent[3];
			res_q.m11        <= ent[4];
			res_q.m12        <= ent[5];
			res_q.m20        <= ent[6];
			res_q.m21        <= ent[7];
			res_q.m22        <= ent[8];
			res_q.degenerate <= deg_d[DIV_ST];
		end
	end

	assign mat.valid = v_q;
	assign mat.data  = res_q;

endmodule

// File: sv/q2rm_chk.sv
// ----------------------------------------------------------------------------
// q2rm_chk
// Port-level checks for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
module q2rm_chk
	import q2rm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic mat_valid,
	input logic mat_ready,
	input mat_t mat_data
);

	// a degenerate result has zero m00, m11, m22, m01, m12 and m20 entries
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && mat_data.degenerate |->
			mat_data.m00 == 0 && mat_data.m11 == 0 && mat_data.m22 == 0 &&
			mat_data.m01 == 0 && mat_data.m12 == 0 && mat_data.m20 == 0)
		else $error("degenerate request with non-zero entries");

	// normalised diagonal never exceeds one
	a_diag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid |->
			mat_data.m00 <= 16'sd16384 && mat_data.m00 >= -16'sd16384 &&
			mat_data.m11 <= 16'sd16384 && mat_data.m11 >= -16'sd16384 &&
			mat_data.m22 <= 16'sd16384 && mat_data.m22 >= -16'sd16384)
		else $error("diagonal entry beyond unit magnitude");

	// pipeline comes up empty
	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !mat_valid)
		else $error("result presented straight after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && !mat_ready |=> mat_valid && $stable(mat_data))
		else $error("stalled result changed");

endmodule

bind quaternion_to_rotation_matrix q2rm_chk u_q2rm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.mat_valid (mat.valid),
	.mat_ready (mat.ready),
	.mat_data  (mat.data)
);
